@@ rtl/display_command_list_player_unit_assert.svh @@
// Assertion macros for the display command list player.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef DISPLAY_COMMAND_LIST_PLAYER_UNIT_ASSERT_SVH
`define DISPLAY_COMMAND_LIST_PLAYER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset
`define DCLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising edge, reset included
`define DCLP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCLP_ASSERT(lbl, prop, msg)
`define DCLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/dclp_pkg.sv @@
// Shared types and constants for the display command list player.
// No dependencies.
package dclp_pkg;

	// Parse phase codes
	localparam logic [2:0] PH_COUNT  = 3'd0;
	localparam logic [2:0] PH_OPCODE = 3'd1;
	localparam logic [2:0] PH_ARGC   = 3'd2;
	localparam logic [2:0] PH_ARGS   = 3'd3;
	localparam logic [2:0] PH_DELAY  = 3'd4;
	localparam logic [2:0] PH_IGNORE = 3'd5;

	// Argument count byte: top bit requests a delay
	localparam int DELAY_FLAG_BIT = 7;

	// Delay byte of all ones means the long delay
	localparam logic [7:0] LONG_DELAY_CODE = 8'd255;
	localparam logic [8:0] LONG_DELAY_MS   = 9'd500;

	// Result kinds
	localparam logic KIND_LINK  = 1'b0;
	localparam logic KIND_DELAY = 1'b1;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] commands_left;
		logic [6:0] args_left;
		logic       delay_pending;
		logic [7:0] held_opcode;
	} state_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] link_byte;
		logic       is_data;
		logic       frame_end;
		logic [8:0] wait_ms;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase:         PH_COUNT,
		commands_left: 8'd0,
		args_left:     7'd0,
		delay_pending: 1'b0,
		held_opcode:   8'd0
	};

endpackage

@@ rtl/dclp_step.sv @@
// Per-byte parser step: next state and optional result word.
// Depends on dclp_pkg.
module dclp_step (
	input  dclp_pkg::state_t  cur,
	input  logic [7:0]        list_byte,
	input  logic              list_last,
	output dclp_pkg::state_t  nxt,
	output logic              emit,
	output dclp_pkg::result_t res
);

	logic [7:0] cmds_dec;
	logic [6:0] args_dec;
	logic [6:0] argc;
	logic [2:0] finish_phase;

	assign cmds_dec     = cur.commands_left - 8'd1;
	assign args_dec     = cur.args_left - 7'd1;
	assign argc         = list_byte[6:0];
	assign finish_phase = (cmds_dec != 8'd0) ? dclp_pkg::PH_OPCODE : dclp_pkg::PH_IGNORE;

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '{
			out_kind:  dclp_pkg::KIND_LINK,
			link_byte: 8'd0,
			is_data:   1'b0,
			frame_end: 1'b0,
			wait_ms:   9'd0
		};

		unique case (cur.phase)
			dclp_pkg::PH_COUNT: begin
				nxt.commands_left = list_byte;
				nxt.phase = (list_byte != 8'd0) ? dclp_pkg::PH_OPCODE : dclp_pkg::PH_IGNORE;
			end
			dclp_pkg::PH_OPCODE: begin
				nxt.held_opcode = list_byte;
				// list ends on the opcode: send it alone as a closed frame
				if (list_last) begin
					emit          = 1'b1;
					res.link_byte = list_byte;
					res.frame_end = 1'b1;
				end
				nxt.phase = dclp_pkg::PH_ARGC;
			end
			dclp_pkg::PH_ARGC: begin
				nxt.args_left     = argc;
				nxt.delay_pending = list_byte[dclp_pkg::DELAY_FLAG_BIT];
				emit              = 1'b1;
				res.link_byte     = cur.held_opcode;
				res.frame_end     = (argc == 7'd0) || list_last;
				if (argc != 7'd0) begin
					nxt.phase = dclp_pkg::PH_ARGS;
				end else if (list_byte[dclp_pkg::DELAY_FLAG_BIT]) begin
					nxt.phase = dclp_pkg::PH_DELAY;
				end else begin
					nxt.commands_left = cmds_dec;
					nxt.delay_pending = 1'b0;
					nxt.args_left     = 7'd0;
					nxt.phase         = finish_phase;
				end
			end
			dclp_pkg::PH_ARGS: begin
				emit          = 1'b1;
				res.link_byte = list_byte;
				res.is_data   = 1'b1;
				res.frame_end = (cur.args_left <= 7'd1) || list_last;
				nxt.args_left = args_dec;
				if (args_dec == 7'd0) begin
					if (cur.delay_pending) begin
						nxt.phase = dclp_pkg::PH_DELAY;
					end else begin
						nxt.commands_left = cmds_dec;
						nxt.delay_pending = 1'b0;
						nxt.args_left     = 7'd0;
						nxt.phase         = finish_phase;
					end
				end
			end
			dclp_pkg::PH_DELAY: begin
				emit         = 1'b1;
				res.out_kind = dclp_pkg::KIND_DELAY;
				res.wait_ms  = (list_byte == dclp_pkg::LONG_DELAY_CODE) ?
					dclp_pkg::LONG_DELAY_MS : {1'b0, list_byte};
				nxt.commands_left = cmds_dec;
				nxt.delay_pending = 1'b0;
				nxt.args_left     = 7'd0;
				nxt.phase         = finish_phase;
			end
			// ignore phase and unused codes: swallow the byte
			default: begin
				nxt = cur;
			end
		endcase

		// end of list buffer: back to expecting a count
		if (list_last) begin
			nxt = dclp_pkg::STATE_RESET;
		end
	end

endmodule

@@ rtl/display_command_list_player_unit.sv @@
// Top level of the display command list player: input register, parser step, result register.
// Depends on dclp_pkg, dclp_step and display_command_list_player_unit_assert.svh.
//
// Takes one list byte per clock while in_stall is low, and gives at most one result word
// per byte, in order. A byte is registered in the input register on acceptance and parsed
// once the output register can take a word; its result is then loaded into the output
// register. Sustained rate is one byte per cycle while the sink does not stall, set by the
// state update in the parser step; in_stall rises only while the output register holds a word
// that the sink is stalling and a further byte is already waiting in the input register.

`include "display_command_list_player_unit_assert.svh"

module display_command_list_player_unit (
	input  logic       clk,
	input  logic       arst_n,
	// list byte channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] list_byte,
	input  logic       list_last,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       out_kind,
	output logic [7:0] link_byte,
	output logic       is_data,
	output logic       frame_end,
	output logic [8:0] wait_ms
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	dclp_pkg::state_t  state_q;
	dclp_pkg::state_t  state_nxt;
	logic              emit;
	dclp_pkg::result_t res;
	dclp_pkg::result_t res_q;
	logic              out_valid_q;
	logic              out_free;
	logic              adv;
	logic              in_take;

	// handshake: stage 1 moves on whenever the output register can take a word
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= list_byte;
			last_s1 <= list_last;
		end
	end

	// parser step
	dclp_step u_step (
		.cur       (state_q),
		.list_byte (byte_s1),
		.list_last (last_s1),
		.nxt       (state_nxt),
		.emit      (emit),
		.res       (res)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dclp_pkg::STATE_RESET;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = res_q.out_kind;
	assign link_byte = res_q.link_byte;
	assign is_data   = res_q.is_data;
	assign frame_end = res_q.frame_end;
	assign wait_ms   = res_q.wait_ms;

	// checks
	`DCLP_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> valid_s1,
		"stall with empty input register")
	`DCLP_ASSERT(a_delay_word_clean,
		(out_valid && out_kind == dclp_pkg::KIND_DELAY) |->
		(wait_ms <= dclp_pkg::LONG_DELAY_MS && link_byte == 8'd0 && !is_data && !frame_end),
		"bad delay word")
	`DCLP_ASSERT(a_link_word_no_wait,
		(out_valid && out_kind == dclp_pkg::KIND_LINK) |-> (wait_ms == 9'd0),
		"link word carries a wait")
	`DCLP_ASSERT(a_last_resets,
		(adv && last_s1) |=>
		(state_q.phase == dclp_pkg::PH_COUNT && state_q.commands_left == 8'd0),
		"list end did not reset parser")

endmodule

@@ tb/sv/display_command_list_player_unit_test.sv @@
// Self-checking testbench for display_command_list_player_unit: predicts every result word
// from the list bytes it feeds in. Depends on dclp_pkg and the RTL of the top level only.
`timescale 1ns / 100ps

// Tracks the parse of the command list and holds the words the block should give
class link_word_board;
	logic [2:0]          step;
	logic [7:0]          cmds_left;
	logic [6:0]          args_to_go;
	logic                delay_due;
	logic [7:0]          opcode_held;
	dclp_pkg::result_t   due_words[$];
	int                  mismatches;

	function new();
		mismatches = 0;
		clear_state();
	endfunction

	function void clear_state();
		step        = dclp_pkg::PH_COUNT;
		cmds_left   = '0;
		args_to_go  = '0;
		delay_due   = 1'b0;
		opcode_held = '0;
	endfunction

	function dclp_pkg::result_t link_word(logic [7:0] b, logic data, logic closing);
		dclp_pkg::result_t w;
		w = '0;
		w.out_kind  = dclp_pkg::KIND_LINK;
		w.link_byte = b;
		w.is_data   = data;
		w.frame_end = closing;
		return w;
	endfunction

	function void close_command();
		cmds_left  = cmds_left - 8'd1;
		delay_due  = 1'b0;
		args_to_go = '0;
		step       = (cmds_left != 0) ? dclp_pkg::PH_OPCODE : dclp_pkg::PH_IGNORE;
	endfunction

	// Accepted list byte: advance the parse, queue any word it causes.
	// Returns 1 when the byte falls in the ignored tail of a list.
	function bit note_byte(logic [7:0] b, logic last);
		dclp_pkg::result_t w;
		bit                emit;
		bit                ignored;
		w       = '0;
		emit    = 1'b0;
		ignored = 1'b0;
		case (step)
			dclp_pkg::PH_COUNT: begin
				cmds_left = b;
				step      = (b != 0) ? dclp_pkg::PH_OPCODE : dclp_pkg::PH_IGNORE;
			end
			dclp_pkg::PH_OPCODE: begin
				opcode_held = b;
				// list cut short: opcode goes out alone and closes the frame
				if (last) begin
					w    = link_word(b, 1'b0, 1'b1);
					emit = 1'b1;
				end
				step = dclp_pkg::PH_ARGC;
			end
			dclp_pkg::PH_ARGC: begin
				args_to_go = b[6:0];
				delay_due  = b[dclp_pkg::DELAY_FLAG_BIT];
				w    = link_word(opcode_held, 1'b0, (b[6:0] == 0) || last);
				emit = 1'b1;
				if (b[6:0] != 0)
					step = dclp_pkg::PH_ARGS;
				else if (delay_due)
					step = dclp_pkg::PH_DELAY;
				else
					close_command();
			end
			dclp_pkg::PH_ARGS: begin
				w    = link_word(b, 1'b1, (args_to_go <= 1) || last);
				emit = 1'b1;
				args_to_go = args_to_go - 7'd1;
				if (args_to_go == 0) begin
					if (delay_due)
						step = dclp_pkg::PH_DELAY;
					else
						close_command();
				end
			end
			dclp_pkg::PH_DELAY: begin
				w.out_kind = dclp_pkg::KIND_DELAY;
				w.wait_ms  = (b == dclp_pkg::LONG_DELAY_CODE) ? dclp_pkg::LONG_DELAY_MS
					: {1'b0, b};
				emit = 1'b1;
				close_command();
			end
			default: begin
				ignored = 1'b1;
			end
		endcase
		if (emit)
			due_words.push_back(w);
		// end of buffer always drops back to expecting a count
		if (last)
			clear_state();
		return ignored;
	endfunction

	function void compare(string what, logic [8:0] want, logic [8:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Accepted result word: compare with the oldest prediction
	function void check_word(logic kind, logic [7:0] lb, logic data, logic fe, logic [8:0] ms);
		dclp_pkg::result_t w;
		if (due_words.size() == 0) begin
			$display("%0t: word expected none, got kind %0b byte %0h data %0b end %0b ms %0d",
				$time, kind, lb, data, fe, ms);
			mismatches++;
			return;
		end
		w = due_words.pop_front();
		compare("out_kind", {8'd0, w.out_kind}, {8'd0, kind});
		compare("link_byte", {1'b0, w.link_byte}, {1'b0, lb});
		compare("is_data", {8'd0, w.is_data}, {8'd0, data});
		compare("frame_end", {8'd0, w.frame_end}, {8'd0, fe});
		compare("wait_ms", w.wait_ms, ms);
	endfunction

	function int outstanding();
		return due_words.size();
	endfunction
endclass

module display_command_list_player_unit_test;
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] list_byte = '0;
	logic       list_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       out_kind;
	logic [7:0] link_byte;
	logic       is_data;
	logic       frame_end;
	logic [8:0] wait_ms;

	link_word_board board;
	logic [7:0]     list_buf[$];
	int             bytes_used = 0;
	int             gap_pct = 20;
	int             stall_pct = 20;
	int             stall_left = 0;
	int unsigned    ticks = 0;
	bit             quiet_tail = 1'b0;

	display_command_list_player_unit i_dut (.*);

	always #1 clk = ~clk;

	// Give up well beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Result side: check accepted words, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word(out_kind, link_byte, is_data, frame_end, wait_ms);
		ticks++;
		if (ticks % 256 == 0)
			stall_pct = $urandom_range(0, 3) * 10;
		if (stall_left != 0) begin
			stall_left--;
			if (stall_left == 0)
				out_stall <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(1, 14);
			out_stall <= 1'b1;
		end
	end

	// Offer one list byte, possibly after an idle burst, and wait for it to be taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		list_byte <= b;
		list_last <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		void'(board.note_byte(b, last));
		bytes_used++;
	endtask

	task automatic play_list();
		foreach (list_buf[i])
			send_byte(list_buf[i], i == list_buf.size() - 1);
		list_buf.delete();
	endtask

	// Mostly well-formed lists with random content; some cut short, some pure noise
	function automatic void make_random_list();
		int         n_cmds;
		int         n_args;
		int         sel;
		int         cap;
		int         cut;
		logic [7:0] argc;
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			repeat ($urandom_range(1, 10))
				list_buf.push_back(8'($urandom));
			return;
		end
		if (sel < 10)
			n_cmds = 0;
		else if (sel < 13)
			n_cmds = $urandom_range(128, 255);
		else
			n_cmds = $urandom_range(1, 6);
		// large counts get truncated early to keep the run short
		cap = (n_cmds > 6) ? 40 : 1000;
		list_buf.push_back(8'(n_cmds));
		for (int c = 0; c < n_cmds && list_buf.size() < cap; c++) begin
			list_buf.push_back(8'($urandom));
			n_args = ($urandom_range(0, 99) == 0) ? $urandom_range(64, 127)
				: $urandom_range(0, 4);
			argc = {1'($urandom_range(0, 1)), 7'(n_args)};
			list_buf.push_back(argc);
			repeat (n_args)
				list_buf.push_back(8'($urandom));
			if (argc[dclp_pkg::DELAY_FLAG_BIT])
				list_buf.push_back(($urandom_range(0, 3) == 0) ? dclp_pkg::LONG_DELAY_CODE
					: 8'($urandom));
		end
		repeat ($urandom_range(0, 3))
			list_buf.push_back(8'($urandom));
		// broken list: end of buffer lands at a random point
		if ($urandom_range(0, 99) < 15) begin
			cut = $urandom_range(1, list_buf.size());
			while (list_buf.size() > cut)
				void'(list_buf.pop_back());
		end
	endfunction

	initial begin
		int guard;
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero command count, tail ignored
		list_buf = {8'h00, 8'hAA, 8'h55};
		play_list();
		// count is the last byte
		list_buf = {8'h05};
		play_list();
		// no-argument command, args with long delay, delay only, ignored tail
		list_buf = {8'h03, 8'h01, 8'h00, 8'hFF, 8'h82, 8'h00, 8'hFF, 8'hFF,
			8'h3A, 8'h80, 8'h00, 8'h99};
		play_list();
		// buffer ends on the opcode
		list_buf = {8'h01, 8'h2C};
		play_list();
		// buffer ends on the argument count
		list_buf = {8'h01, 8'h2A, 8'h84};
		play_list();
		// buffer ends mid-arguments
		list_buf = {8'h01, 8'h2B, 8'h03, 8'h11, 8'h22};
		play_list();
		// buffer ends on the delay byte
		list_buf = {8'h01, 8'h11, 8'h80, 8'h78};
		play_list();

		// hold the source until the sink has caught up
		in_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);

		while (bytes_used < 1550) begin
			gap_pct = $urandom_range(0, 2) * 15;
			if (bytes_used > 1350)
				quiet_tail = 1'b1;
			make_random_list();
			play_list();
		end

		// drain
		in_valid <= 1'b0;
		guard = 0;
		while (board.outstanding() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (board.outstanding() != 0)
			$display("%0t: %0d predicted words never arrived", $time, board.outstanding());
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
